### hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Every macro samples on i_clk and is muted while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define GCBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define GCBC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GCBC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/gcbc_pkg.sv
// Package for the gradient colormap core: palette tables, codes, pipeline
// control type and the divide-by-1000 reciprocal helper. No dependencies.
`default_nettype none

package gcbc_pkg;

    localparam int NumStages = 6;
    localparam int NumChan   = 3;

    // floor(x/1000) == (x * Recip1000) >> RecipShift for all x < 2^21
    localparam int          RecipShift = 30;
    localparam logic [20:0] Recip1000  = 21'd1073742;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        PAL_AURORA   = 3'd0,
        PAL_OCEANIC  = 3'd1,
        PAL_PHOSPHOR = 3'd2,
        PAL_DARKROOM = 3'd3,
        PAL_EMBER    = 3'd4
    } t_palette;

    typedef enum logic [1:0] {
        REG_PALETTE    = 2'd0,
        REG_BRIGHTNESS = 2'd1,
        REG_CONTRAST   = 2'd2
    } t_reg_idx;

    // rows follow t_palette, columns are red, green, blue
    localparam t_byte PalLow [5][NumChan] = '{
        '{8'd4,  8'd18, 8'd42},
        '{8'd5,  8'd14, 8'd55},
        '{8'd3,  8'd24, 8'd8},
        '{8'd10, 8'd7,  8'd6},
        '{8'd16, 8'd3,  8'd1}
    };

    localparam t_byte PalHigh [5][NumChan] = '{
        '{8'd124, 8'd246, 8'd218},
        '{8'd92,  8'd190, 8'd252},
        '{8'd176, 8'd255, 8'd154},
        '{8'd126, 8'd64,  8'd42},
        '{8'd255, 8'd166, 8'd44}
    };

    typedef struct packed {
        logic [NumStages-1:0] load;   // per-stage register enable
    } t_pipe_ctl;

    // unknown palette codes fall back to ember
    function automatic logic [2:0] pal_row(input logic [2:0] sel);
        logic [2:0] row;
        row = (sel > PAL_EMBER) ? PAL_EMBER : sel;
        return row;
    endfunction

    function automatic logic [11:0] div1000(input logic [20:0] x);
        logic [41:0] prod;
        prod = 42'(x) * 42'(Recip1000);
        return prod[RecipShift +: 12];
    endfunction

endpackage

`default_nettype wire

### hdl/gcbc_ctrl.sv
// Valid/ready control for the colormap pipeline: one valid bit per stage
// and a bubble-collapsing load chain. Uses gcbc_pkg.
`default_nettype none

module gcbc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output gcbc_pkg::t_pipe_ctl    o_ctl
);
    import gcbc_pkg::*;

    logic [NumStages-1:0] r_vld;
    logic [NumStages-1:0] n_vld;
    logic [NumStages:0]   w_load;

    // a stage loads when empty or when its content moves on
    always_comb begin
        w_load[NumStages] = i_m_tready;
        for (int k = NumStages - 1; k >= 0; k--) begin
            w_load[k] = !r_vld[k] || w_load[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < NumStages; k++) begin
            if (w_load[k]) begin
                n_vld[k] = (k == 0) ? i_s_tvalid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.load = w_load[NumStages-1:0];
    assign o_s_tready = w_load[0];
    assign o_m_tvalid = r_vld[NumStages-1];

endmodule

`default_nettype wire

### hdl/gcbc_channel.sv
// One color channel datapath: interpolate, brightness, contrast, clamp,
// six register stages. Uses gcbc_pkg (div1000, t_pipe_ctl).
`default_nettype none

module gcbc_channel (
    input  wire logic                i_clk,
    input  wire gcbc_pkg::t_pipe_ctl i_ctl,
    input  wire logic [7:0]          i_lo,
    input  wire logic [7:0]          i_span,
    input  wire logic [9:0]          i_field,
    input  wire logic [10:0]         i_bright_gain,
    input  wire logic [10:0]         i_contrast_gain,
    output logic [7:0]               o_byte
);
    import gcbc_pkg::*;

    logic [17:0] r_prod1;
    logic [7:0]  r_lo;
    logic [8:0]  r_v1;
    logic [19:0] r_prod2;
    logic [9:0]  r_v2;
    logic [20:0] r_mag;
    logic        r_neg;
    logic [7:0]  r_out;

    logic [11:0] w_q1;
    logic [11:0] w_q2;
    logic [11:0] w_q3;
    logic [7:0]  n_out;

    assign w_q1 = div1000(21'(r_prod1));
    assign w_q2 = div1000(21'(r_prod2));
    assign w_q3 = div1000(r_mag);

    // contrast divide truncates toward zero, so work on the magnitude
    always_comb begin
        if (r_neg) begin
            n_out = (w_q3 >= 12'd128) ? 8'd0 : 8'(12'd128 - w_q3);
        end else begin
            n_out = (w_q3 >= 12'd128) ? 8'd255 : 8'(12'd128 + w_q3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_prod1 <= 18'(i_span) * 18'(i_field);
            r_lo    <= i_lo;
        end
        if (i_ctl.load[1]) begin
            r_v1 <= 9'(r_lo) + w_q1[8:0];
        end
        if (i_ctl.load[2]) begin
            r_prod2 <= 20'(r_v1) * 20'(i_bright_gain);
        end
        if (i_ctl.load[3]) begin
            r_v2 <= w_q2[9:0];
        end
        if (i_ctl.load[4]) begin
            if (r_v2 >= 10'd128) begin
                r_mag <= 21'(r_v2 - 10'd128) * 21'(i_contrast_gain);
                r_neg <= 1'b0;
            end else begin
                r_mag <= 21'(10'd128 - r_v2) * 21'(i_contrast_gain);
                r_neg <= 1'b1;
            end
        end
        if (i_ctl.load[5]) begin
            r_out <= n_out;
        end
    end

    assign o_byte = r_out;

endmodule

`default_nettype wire

### hdl/gradient_colormap_brightness_contrast_core.sv
// Top level of the gradient colormap core: config registers, palette
// lookup, pipeline control and three channel datapaths. Uses gcbc_pkg.
//
//  channel   direction  tdata / fields                 handshake
//  s (in)    slave      [9:0] sample                   i_s_tvalid / o_s_tready
//  m (out)   master     [7:0] red [15:8] green         o_m_tvalid / i_m_tready
//                       [23:16] blue
//  cfg       write      addr 0 palette, 1 brightness,  i_cfg_we (no wait)
//                       2 contrast
//
// Six register stages; a request accepted into the first stage moves through all
// six to o_m_tvalid, and one request is taken every cycle while the sink keeps up.
// The stage count is set by the three reciprocal multiply-by-1000 divides,
// each with its own product stage ahead of it.
// o_s_tready follows the per-stage valid bits: bubbles collapse, stalls only
// propagate back through full stages, nothing is dropped or repeated.
// Synchronous active-low reset empties the pipe and loads palette 4 and
// gains of 1000 (brightness and contrast 500).
`default_nettype none
`include "assert_macros.svh"

module gradient_colormap_brightness_contrast_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // stream in
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [9:0] sample, [15:10] zero
    // stream out
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    // config write
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [9:0]  i_cfg_wdata
);
    import gcbc_pkg::*;

    logic [2:0]  r_palette;
    logic [10:0] r_bright_gain;    // brightness + 500
    logic [10:0] r_contrast_gain;  // contrast + 500

    t_pipe_ctl   w_ctl;
    logic [2:0]  w_row;

    // gains are kept pre-offset so the datapath sees them directly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette       <= PAL_EMBER;
            r_bright_gain   <= 11'd1000;
            r_contrast_gain <= 11'd1000;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_PALETTE:    r_palette       <= i_cfg_wdata[2:0];
                REG_BRIGHTNESS: r_bright_gain   <= 11'(i_cfg_wdata) + 11'd500;
                REG_CONTRAST:   r_contrast_gain <= 11'(i_cfg_wdata) + 11'd500;
                default: ;
            endcase
        end
    end

    gcbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_ctl      (w_ctl)
    );

    // codes 5..7 map to ember
    assign w_row = pal_row(r_palette);

    for (genvar g = 0; g < NumChan; g++) begin : g_chan
        logic [7:0] w_lo;
        logic [7:0] w_span;
        logic [7:0] w_byte;

        // every palette pair has high >= low, so the span is unsigned
        assign w_lo   = PalLow[w_row][g];
        assign w_span = PalHigh[w_row][g] - PalLow[w_row][g];

        gcbc_channel u_chan (
            .i_clk           (i_clk),
            .i_ctl           (w_ctl),
            .i_lo            (w_lo),
            .i_span          (w_span),
            .i_field         (i_s_tdata[9:0]),
            .i_bright_gain   (r_bright_gain),
            .i_contrast_gain (r_contrast_gain),
            .o_byte          (w_byte)
        );

        assign o_m_tdata[8*g +: 8] = w_byte;
    end

    // an empty output stage implies room all the way back to the input
    `GCBC_ASSERT_IMP(a_empty_out_ready, !o_m_tvalid, o_s_tready, "input blocked with empty output")
    // a ready sink must never hold back the input
    `GCBC_ASSERT_IMP(a_sink_ready_ready, i_m_tready, o_s_tready, "input blocked with ready sink")
    // gain registers always carry the +500 offset
    `GCBC_ASSERT(a_bright_gain_ofs, r_bright_gain >= 11'd500, "brightness offset lost")
    `GCBC_ASSERT(a_contrast_gain_ofs, r_contrast_gain >= 11'd500, "contrast offset lost")

endmodule

`default_nettype wire
